### src/snlag_pkg.sv
`timescale 1ns / 1ps

package snlag_pkg;

    localparam int MaxDimsDefault = 8;

    localparam int AddrW   = 48;
    localparam int SizeW   = 16;
    localparam int StrideW = 32;
    localparam int BytesW  = 5;
    localparam int DimsW   = 4;
    localparam int IdxW    = 3;
    localparam int PaddrW  = 4;

    typedef logic [1:0]         t_opcode;
    typedef logic [AddrW-1:0]   t_addr;
    typedef logic [SizeW-1:0]   t_size;
    typedef logic [StrideW-1:0] t_stride;
    typedef logic [BytesW-1:0]  t_bytes;

    localparam t_opcode OP_LOAD  = 2'd0;
    localparam t_opcode OP_START = 2'd1;
    localparam t_opcode OP_NEXT  = 2'd2;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_DIMS      = 2'd0;
    localparam logic [1:0] REG_BYTES_IN  = 2'd1;
    localparam logic [1:0] REG_BYTES_OUT = 2'd2;

    localparam logic [DimsW-1:0]  DIMS_RST  = 4'd1;
    localparam logic [BytesW-1:0] BYTES_RST = 5'd4;

    // partial sums handed from cell to cell
    typedef struct packed {
        logic  vld;
        logic  last;
        t_addr in_addr;
        t_addr out_addr;
    } t_link;

    typedef struct packed {
        logic ld;
        logic clr;
        logic adv;
        logic used;
    } t_cell_ctrl;

    typedef struct packed {
        logic  last;
        t_addr in_addr;
        t_addr out_addr;
    } t_result;

endpackage

### src/strided_nested_loop_address_gen_core.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle on both sides, pairs back to back, while m_axis_tready holds.
// Path: a pair beat reaches the master side through r_s1 and r_s2, alongside one multiply stage
//   and the byte-scaling stage, then one adder per cell and the skid output register.
// The skid register catches one more result while the output register waits; then s_axis_tready drops.
// Reset (synchronous, active low): walk idle, tables, counters and bases zero,
//   dims_in_use 1, element sizes 4 bytes.

module strided_nested_loop_address_gen_core #(
    parameter int MAX_DIMS = snlag_pkg::MaxDimsDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // dim_index[2:0], dim_size[18:3], in_stride[50:19], out_stride[82:51],
    // in_base[130:83], out_base[178:131], zero pad[183:179]
    input  logic [183:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // in_address[47:0], out_address[95:48]
    output logic [95:0]  m_axis_tdata,
    // final_pair
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import snlag_pkg::*;

    logic [DimsW-1:0] r_dims;
    t_bytes           r_bytes_in;
    t_bytes           r_bytes_out;
    t_addr            r_in_start;
    t_addr            r_out_start;
    logic             r_active;

    t_opcode          w_op;
    logic [IdxW-1:0]  w_dim_index;
    t_size            w_dim_size;
    t_stride          w_in_stride;
    t_stride          w_out_stride;
    t_addr            w_in_base;
    t_addr            w_out_base;

    logic             w_en;
    logic             w_fire;
    logic             w_next;
    logic             w_empty;
    logic             w_final;
    logic             w_emit;
    logic             w_wr;

    logic [MAX_DIMS-1:0] w_empty_vec;
    logic                w_carry [MAX_DIMS+1];
    t_link               w_link  [MAX_DIMS+1];
    t_cell_ctrl          w_ctrl  [MAX_DIMS];
    t_link               r_s1;
    t_link               r_s2;
    t_result             w_res_in;
    t_result             w_res_out;

    assign w_op         = s_axis_tuser;
    assign w_dim_index  = s_axis_tdata[2:0];
    assign w_dim_size   = s_axis_tdata[18:3];
    assign w_in_stride  = s_axis_tdata[50:19];
    assign w_out_stride = s_axis_tdata[82:51];
    assign w_in_base    = s_axis_tdata[130:83];
    assign w_out_base   = s_axis_tdata[178:131];

    assign s_axis_tready = w_en;
    assign w_fire  = s_axis_tvalid && w_en;
    assign w_next  = w_fire && (w_op == OP_NEXT) && r_active;
    assign w_empty = |w_empty_vec;
    assign w_final = w_carry[0];
    assign w_emit  = w_next && !w_empty;

    // configuration port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_DIMS:      prdata = {28'd0, r_dims};
            REG_BYTES_IN:  prdata = {27'd0, r_bytes_in};
            REG_BYTES_OUT: prdata = {27'd0, r_bytes_out};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims      <= DIMS_RST;
            r_bytes_in  <= BYTES_RST;
            r_bytes_out <= BYTES_RST;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_DIMS:      r_dims      <= pwdata[DimsW-1:0];
                REG_BYTES_IN:  r_bytes_in  <= pwdata[BytesW-1:0];
                REG_BYTES_OUT: r_bytes_out <= pwdata[BytesW-1:0];
                default: ;
            endcase
        end
    end

    // walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_in_start  <= '0;
            r_out_start <= '0;
        end else if (w_fire && (w_op == OP_START)) begin
            r_active    <= 1'b1;
            r_in_start  <= w_in_base;
            r_out_start <= w_out_base;
        end else if (w_next && (w_empty || w_final)) begin
            r_active <= 1'b0;
        end
    end

    // base addresses enter the chain through r_s1 and r_s2, alongside the first term
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
        end else if (w_en) begin
            r_s1.vld <= w_emit;
            r_s2.vld <= r_s1.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1.last     <= w_final;
            r_s1.in_addr  <= r_in_start;
            r_s1.out_addr <= r_out_start;
            r_s2.last     <= r_s1.last;
            r_s2.in_addr  <= r_s1.in_addr;
            r_s2.out_addr <= r_s1.out_addr;
        end
    end

    assign w_link[0]         = r_s2;
    assign w_carry[MAX_DIMS] = 1'b1;

    for (genvar k = 0; k < MAX_DIMS; k++) begin : g_cell
        assign w_ctrl[k].ld   = w_fire && (w_op == OP_LOAD) && (32'(w_dim_index) == k);
        assign w_ctrl[k].clr  = w_fire && (w_op == OP_START);
        assign w_ctrl[k].adv  = w_emit && !w_final;
        assign w_ctrl[k].used = (k == 0) || (32'(r_dims) > k);

        snlag_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_en            (w_en),
            .i_ctrl          (w_ctrl[k]),
            .i_ld_size       (w_dim_size),
            .i_ld_in_stride  (w_in_stride),
            .i_ld_out_stride (w_out_stride),
            .i_bytes_in      (r_bytes_in),
            .i_bytes_out     (r_bytes_out),
            .i_carry         (w_carry[k+1]),
            .o_carry         (w_carry[k]),
            .o_empty         (w_empty_vec[k]),
            .i_link          (w_link[k]),
            .o_link          (w_link[k+1])
        );
    end

    assign w_res_in.last     = w_link[MAX_DIMS].last;
    assign w_res_in.in_addr  = w_link[MAX_DIMS].in_addr;
    assign w_res_in.out_addr = w_link[MAX_DIMS].out_addr;

    snlag_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_link[MAX_DIMS].vld),
        .i_data  (w_res_in),
        .o_ready (w_en),
        .o_vld   (m_axis_tvalid),
        .o_data  (w_res_out),
        .i_take  (m_axis_tready)
    );

    assign m_axis_tdata = {w_res_out.out_addr, w_res_out.in_addr};
    assign m_axis_tlast = w_res_out.last;

    a_idle_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (w_op == OP_NEXT) && !r_active) |=> !r_s1.vld)
        else $error("pair issued with no walk armed");

    a_final_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_final) |=> (!r_active && r_s1.vld && r_s1.last))
        else $error("last pair did not end the walk");

    a_empty_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_next && w_empty) |=> (!r_active && !r_s1.vld))
        else $error("empty loop issued a pair or stayed armed");

endmodule

### src/snlag_cell.sv
`timescale 1ns / 1ps

module snlag_cell #(
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  snlag_pkg::t_cell_ctrl i_ctrl,
    input  snlag_pkg::t_size     i_ld_size,
    input  snlag_pkg::t_stride   i_ld_in_stride,
    input  snlag_pkg::t_stride   i_ld_out_stride,
    input  snlag_pkg::t_bytes    i_bytes_in,
    input  snlag_pkg::t_bytes    i_bytes_out,
    input  logic                 i_carry,
    output logic                 o_carry,
    output logic                 o_empty,
    input  snlag_pkg::t_link     i_link,
    output snlag_pkg::t_link     o_link
);
    import snlag_pkg::*;

    t_size                     r_size;
    logic signed [StrideW-1:0] r_in_stride;
    logic signed [StrideW-1:0] r_out_stride;
    t_size                     r_cnt;
    t_size                     n_cnt;

    logic                      w_at_last;
    logic signed [AddrW:0]     w_prod_in;
    logic signed [AddrW:0]     w_prod_out;

    t_addr                     r_pipe_in  [IDX+1];
    t_addr                     r_pipe_out [IDX+1];
    t_addr                     r_term_in;
    t_addr                     r_term_out;
    t_link                     r_link;

    assign w_at_last = ({1'b0, r_cnt} + 17'd1) >= {1'b0, r_size};
    assign o_carry   = i_ctrl.used ? (i_carry & w_at_last) : i_carry;
    assign o_empty   = i_ctrl.used & (r_size == '0);

    assign w_prod_in  = $signed({1'b0, r_cnt}) * r_in_stride;
    assign w_prod_out = $signed({1'b0, r_cnt}) * r_out_stride;

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctrl.clr) begin
            n_cnt = '0;
        end else if (i_ctrl.adv && i_ctrl.used && i_carry) begin
            n_cnt = w_at_last ? '0 : r_cnt + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size       <= '0;
            r_in_stride  <= '0;
            r_out_stride <= '0;
            r_cnt        <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_ctrl.ld) begin
                r_size       <= i_ld_size;
                r_in_stride  <= i_ld_in_stride;
                r_out_stride <= i_ld_out_stride;
            end
        end
    end

    // cell IDX delays its term through r_pipe_in/r_pipe_out[1..IDX], in step with the links before it
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe_in[0]  <= i_ctrl.used ? w_prod_in[AddrW-1:0] : '0;
            r_pipe_out[0] <= i_ctrl.used ? w_prod_out[AddrW-1:0] : '0;
            for (int i = 1; i <= IDX; i++) begin
                r_pipe_in[i]  <= r_pipe_in[i-1];
                r_pipe_out[i] <= r_pipe_out[i-1];
            end
            r_term_in  <= r_pipe_in[IDX]  * {{(AddrW-BytesW){1'b0}}, i_bytes_in};
            r_term_out <= r_pipe_out[IDX] * {{(AddrW-BytesW){1'b0}}, i_bytes_out};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.vld <= 1'b0;
        end else if (i_en) begin
            r_link.vld <= i_link.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_link.last     <= i_link.last;
            r_link.in_addr  <= i_link.in_addr + r_term_in;
            r_link.out_addr <= i_link.out_addr + r_term_out;
        end
    end

    assign o_link = r_link;

endmodule

### src/snlag_skid.sv
`timescale 1ns / 1ps

module snlag_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  snlag_pkg::t_result i_data,
    output logic               o_ready,
    output logic               o_vld,
    output snlag_pkg::t_result o_data,
    input  logic               i_take
);
    import snlag_pkg::*;

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out;
    t_result r_skid;
    logic    w_take;
    logic    w_push;

    assign o_ready = !r_skid_vld;
    assign w_take  = r_out_vld && i_take;
    assign w_push  = i_vld && !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_vld || w_take) begin
                r_out     <= i_data;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= i_data;
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_vld  = r_out_vld;
    assign o_data = r_out;

endmodule
